@@ design/tafc_pkg.sv @@
// Shared types, register indexes and constants for the temperature alert fan controller.
`default_nettype none

package tafc_pkg;

  localparam int unsigned TEMP_W = 20;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned IDX_W  = 2;

  // Mode codes
  localparam logic [1:0] MODE_REST  = 2'd0;
  localparam logic [1:0] MODE_ALERT = 2'd1;
  localparam logic [1:0] MODE_VENT  = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [IDX_W-1:0] REG_ALERT_THR  = 2'd0;
  localparam logic [IDX_W-1:0] REG_REST_THR   = 2'd1;
  localparam logic [IDX_W-1:0] REG_ALERT_HOLD = 2'd2;
  localparam logic [IDX_W-1:0] REG_VENT_MAX   = 2'd3;

  // Reset values: 28.0 C, 26.0 C, 10 s, 120 s, 20.0 C
  localparam logic [TEMP_W-1:0] ALERT_THR_RST  = 20'd408944;
  localparam logic [TEMP_W-1:0] REST_THR_RST   = 20'd398459;
  localparam logic [TIME_W-1:0] ALERT_HOLD_RST = 32'd10000000;
  localparam logic [TIME_W-1:0] VENT_MAX_RST   = 32'd120000000;
  localparam logic [TEMP_W-1:0] TEMP_RST       = 20'd367002;

  localparam int unsigned BUSY_BIT = 7;

  typedef struct packed {
    logic [TEMP_W-1:0] alert_threshold;
    logic [TEMP_W-1:0] rest_threshold;
    logic [TIME_W-1:0] alert_hold_us;
    logic [TIME_W-1:0] vent_max_us;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic              read_complete;
    logic [7:0]        sensor_status;
    logic [TEMP_W-1:0] temp_code;
    logic [TIME_W-1:0] now_us;
  } item_t;

endpackage

`default_nettype wire

@@ design/tafc_regs.sv @@
// APB configuration registers for the temperature alert fan controller.
`default_nettype none

module tafc_regs
  import tafc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alert_threshold <= ALERT_THR_RST;
      cfg.rest_threshold  <= REST_THR_RST;
      cfg.alert_hold_us   <= ALERT_HOLD_RST;
      cfg.vent_max_us     <= VENT_MAX_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ALERT_THR:  cfg.alert_threshold <= pwdata[TEMP_W-1:0];
        REG_REST_THR:   cfg.rest_threshold  <= pwdata[TEMP_W-1:0];
        REG_ALERT_HOLD: cfg.alert_hold_us   <= pwdata[TIME_W-1:0];
        REG_VENT_MAX:   cfg.vent_max_us     <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ALERT_THR:  prdata = {{(DATA_W-TEMP_W){1'b0}}, cfg.alert_threshold};
      REG_REST_THR:   prdata = {{(DATA_W-TEMP_W){1'b0}}, cfg.rest_threshold};
      REG_ALERT_HOLD: prdata = cfg.alert_hold_us;
      REG_VENT_MAX:   prdata = cfg.vent_max_us;
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/tafc_core.sv @@
// Input register, mode machine and result register of the fan controller.
`default_nettype none

module tafc_core
  import tafc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire item_t             in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [1:0]        mode,
  output logic                   fan_on,
  output logic      [TEMP_W-1:0] stored_temp
);

  // Input register
  logic  s1_valid;
  item_t s1_item;
  logic  adv;

  // Controller state
  logic [1:0]        mode_reg, mode_next;
  logic              fan_reg, fan_next;
  logic [TEMP_W-1:0] temp_reg, temp_next;
  logic [TIME_W-1:0] alert_start, alert_start_next;
  logic [TIME_W-1:0] vent_start, vent_start_next;

  logic [TIME_W-1:0] alert_elapsed, vent_elapsed;
  logic              in_take;

  // Advance the held item when the result slot is empty or being drained
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= in_item;
    end
  end

  assign alert_elapsed = s1_item.now_us - alert_start;
  assign vent_elapsed  = s1_item.now_us - vent_start;

  always_comb begin
    mode_next        = mode_reg;
    fan_next         = fan_reg;
    temp_next        = temp_reg;
    alert_start_next = alert_start;
    vent_start_next  = vent_start;
    if (!s1_item.action) begin
      if (s1_item.read_complete && !s1_item.sensor_status[BUSY_BIT]) begin
        temp_next = s1_item.temp_code;
      end
    end else begin
      unique case (mode_reg)
        MODE_ALERT: begin
          if (temp_reg <= cfg.alert_threshold) begin
            mode_next = MODE_REST;
          end else if (alert_elapsed >= cfg.alert_hold_us) begin
            mode_next       = MODE_VENT;
            vent_start_next = s1_item.now_us;
            fan_next        = 1'b1;
          end
        end
        MODE_VENT: begin
          if (temp_reg < cfg.rest_threshold || vent_elapsed >= cfg.vent_max_us) begin
            mode_next = MODE_REST;
            fan_next  = 1'b0;
          end
        end
        default: begin
          if (temp_reg > cfg.alert_threshold) begin
            mode_next        = MODE_ALERT;
            alert_start_next = s1_item.now_us;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= MODE_REST;
      fan_reg     <= 1'b0;
      temp_reg    <= TEMP_RST;
      alert_start <= '0;
      vent_start  <= '0;
    end else if (adv) begin
      mode_reg    <= mode_next;
      fan_reg     <= fan_next;
      temp_reg    <= temp_next;
      alert_start <= alert_start_next;
      vent_start  <= vent_start_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode        <= mode_next;
      fan_on      <= fan_next;
      stored_temp <= temp_next;
    end
  end

`ifndef SYNTHESIS
  a_fan_matches_mode: assert property (@(posedge clk) disable iff (rst)
    fan_reg == (mode_reg == MODE_VENT))
    else $error("fan level disagrees with mode");

  a_no_rest_to_vent: assert property (@(posedge clk) disable iff (rst)
    (adv && mode_reg == MODE_REST) |=> mode_reg != MODE_VENT)
    else $error("rest went straight to ventilating");

  a_sensor_keeps_mode: assert property (@(posedge clk) disable iff (rst)
    (adv && !s1_item.action) |=> (mode_reg == $past(mode_reg) && fan_reg == $past(fan_reg)))
    else $error("sensor item changed mode or fan");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    adv |=> (mode == mode_reg && stored_temp == temp_reg && fan_on == fan_reg))
    else $error("result register disagrees with state");
`endif

endmodule

`default_nettype wire

@@ design/temp_alert_fan_controller.sv @@
// Top level of the temperature alert fan controller: config registers and core.
// Path: an accepted item is held in the input register, its result is written to the
//   result register, and it transfers out from there when the output is not stalled.
// Throughput: one item per cycle while out_stall is low; the mode machine and both
//   elapsed-time subtractions are combinational between the input and result registers.
// Reset (rst, synchronous): mode rest, fan off, code 367002 (20.0 C), times zero, defaults.
`default_nettype none

module temp_alert_fan_controller
  import tafc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Item channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              action,
  input  wire logic              read_complete,
  input  wire logic [7:0]        sensor_status,
  input  wire logic [TEMP_W-1:0] temp_code,
  input  wire logic [TIME_W-1:0] now_us,
  // Result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [1:0]        mode,
  output logic                   fan_on,
  output logic      [TEMP_W-1:0] stored_temp,
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t  cfg;
  item_t in_item;

  // Bundle the item fields for the input register
  assign in_item = {action, read_complete, sensor_status, temp_code, now_us};

  // Thresholds and times; the user must write them only while no transfer is in flight (not enforced here)
  tafc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Hold the item, step the mode machine, register the result
  tafc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mode        (mode),
    .fan_on      (fan_on),
    .stored_temp (stored_temp)
  );

endmodule

`default_nettype wire
